[hdl/msie_pkg.sv]
// Shared types and instruction codes for the MIPS subset execute block.
`timescale 1ns / 1ps
`default_nettype none
package msie_pkg;

  localparam int unsigned DataWordsDef = 1024;
  localparam logic [31:0] PcReset      = 32'h0040_0000;
  localparam logic [15:0] LenReset     = 16'hFFFF;

  typedef enum logic [1:0] {
    OpExec    = 2'd0,
    OpPreload = 2'd1,
    OpReadReg = 2'd2,
    OpReadMem = 2'd3
  } item_op_e;

  typedef enum logic [1:0] {
    RdNone = 2'd0,
    RdReg  = 2'd1,
    RdMem  = 2'd2
  } read_sel_e;

  typedef enum logic {
    CfgTextBase = 1'b0,
    CfgProgLen  = 1'b1
  } cfg_idx_e;

  // Major opcodes.
  localparam logic [5:0] OpcSpecial = 6'h00;
  localparam logic [5:0] OpcJ       = 6'h02;
  localparam logic [5:0] OpcJal     = 6'h03;
  localparam logic [5:0] OpcBeq     = 6'h04;
  localparam logic [5:0] OpcBne     = 6'h05;
  localparam logic [5:0] OpcAddiu   = 6'h09;
  localparam logic [5:0] OpcSltiu   = 6'h0b;
  localparam logic [5:0] OpcAndi    = 6'h0c;
  localparam logic [5:0] OpcOri     = 6'h0d;
  localparam logic [5:0] OpcLui     = 6'h0f;
  localparam logic [5:0] OpcLw      = 6'h23;
  localparam logic [5:0] OpcSw      = 6'h2b;

  // Function codes of the special opcode.
  localparam logic [5:0] FnSll  = 6'h00;
  localparam logic [5:0] FnSrl  = 6'h02;
  localparam logic [5:0] FnJr   = 6'h08;
  localparam logic [5:0] FnAddu = 6'h21;
  localparam logic [5:0] FnSubu = 6'h23;
  localparam logic [5:0] FnAnd  = 6'h24;
  localparam logic [5:0] FnOr   = 6'h25;
  localparam logic [5:0] FnNor  = 6'h27;
  localparam logic [5:0] FnSltu = 6'h2b;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

endpackage
`default_nettype wire

[hdl/msie_regfile.sv]
// Register file memory: two registered read ports, one write port, zero at reset.
`timescale 1ns / 1ps
`default_nettype none
module msie_regfile
  import msie_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [4:0]  raddr_a_i,
  input  wire logic [4:0]  raddr_b_i,
  input  wire rf_wr_t      wr_i,
  output logic      [31:0] rdata_a_o,
  output logic      [31:0] rdata_b_o
);

  logic [31:0] mem [32];
  logic [31:0] valid_q;
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  // Entries that were never written read as zero; register 0 never gets written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i && wr_i.en && (wr_i.addr != 5'd0)) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wr_i.en && (wr_i.addr != 5'd0)) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_a_q <= valid_q[raddr_a_i] ? mem[raddr_a_i] : 32'd0;
      rdata_b_q <= valid_q[raddr_b_i] ? mem[raddr_b_i] : 32'd0;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

[hdl/mips_subset_instruction_execute.sv]
// Stages: register file read, execute, memory/writeback, then the output register.
// Throughput: one item per cycle while the output is not stalled; the register
// file memory read, the execute stage and the data memory read overlap, with
// forwarding. The PC and run flag loops each close through a single register.
// Reset clears the register file (valid bits) and loads the PC, run flag and
// config with their reset values; the data memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module mips_subset_instruction_execute
  import msie_pkg::*;
#(
  parameter int unsigned DATA_WORDS = DataWordsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] instr_word, [41:32] slot_index, [73:42] write_value, rest zero
  input  wire logic [79:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] next_pc, [32] running, [64:33] read_value, rest zero
  output logic      [71:0] m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(DATA_WORDS);

  logic        en;
  logic [31:0] text_base_q;
  logic [15:0] prog_len_q;
  logic [31:0] pc_q;
  logic        run_q;

  // Execute stage registers.
  logic        s2_valid_q;
  item_op_e    s2_op_q;
  logic [31:0] s2_instr_q;
  logic [9:0]  s2_slot_q;
  logic [31:0] s2_wval_q;
  logic [4:0]  s2_ra_q;
  logic [4:0]  s2_rb_q;

  // Memory / writeback stage registers.
  logic        s3_valid_q;
  rf_wr_t      s3_wr_q;
  logic        s3_load_q;
  logic        s3_chk_q;
  logic [31:0] s3_npc_q;
  read_sel_e   s3_rsel_q;
  logic [31:0] s3_rv_q;

  rf_wr_t      w_q;
  logic        out_valid_q;
  logic [71:0] out_data_q;

  logic [31:0] dmem [DATA_WORDS];
  logic [31:0] dm_rdata_q;

  logic [31:0] rf_a, rf_b;
  logic [4:0]  in_ra, in_rb;
  rf_wr_t      rf_wr;

  // Execute stage combinational outputs.
  logic [31:0] a, b, npc, alu;
  logic        run_eff, past_end, exec_en, wr_en, is_load;
  logic [4:0]  wr_addr;
  logic        dm_we;
  logic [AW-1:0] dm_addr;
  logic [31:0] dm_wdata;
  read_sel_e   rsel;
  logic [31:0] s3_wdata, diff, ea, seq, simm, zimm, slot_ext;
  logic [5:0]  opc, fn;
  logic [4:0]  rt, rd, sh;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_base_q <= PcReset;
      prog_len_q  <= LenReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgTextBase: text_base_q <= cfg_data_i;
        CfgProgLen:  prog_len_q  <= cfg_data_i[15:0];
      endcase
    end
  end

  // Register read addresses; a read-register item uses port A.
  always_comb begin
    in_ra = s_axis_tdata[25:21];
    in_rb = s_axis_tdata[20:16];
    if (item_op_e'(s_axis_tuser) == OpReadReg) begin
      in_ra = s_axis_tdata[36:32];
    end
  end

  msie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .raddr_a_i (in_ra),
    .raddr_b_i (in_rb),
    .wr_i      (rf_wr),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q    <= item_op_e'(s_axis_tuser);
      s2_instr_q <= s_axis_tdata[31:0];
      s2_slot_q  <= s_axis_tdata[41:32];
      s2_wval_q  <= s_axis_tdata[73:42];
      s2_ra_q    <= in_ra;
      s2_rb_q    <= in_rb;
    end
  end

  // End-of-program check on the PC left by the item in the writeback stage.
  always_comb begin
    diff = s3_npc_q - text_base_q;
    if (!diff[31]) begin
      past_end = ({2'b00, diff[31:2]} >= {16'd0, prog_len_q});
    end else begin
      past_end = (&diff[31:2]) && (diff[1:0] != 2'b00) && (prog_len_q == 16'd0);
    end
    run_eff = run_q && !(s3_valid_q && s3_chk_q && past_end);
  end

  assign s3_wdata = s3_load_q ? dm_rdata_q : s3_wr_q.data;
  always_comb begin
    rf_wr      = s3_wr_q;
    rf_wr.en   = s3_valid_q && s3_wr_q.en;
    rf_wr.data = s3_wdata;
  end

  // Operand forwarding: the writeback stage first, then the write that
  // landed in the memory at the same edge as this item's read.
  always_comb begin
    a = rf_a;
    b = rf_b;
    if (w_q.en && (w_q.addr == s2_ra_q)) a = w_q.data;
    if (w_q.en && (w_q.addr == s2_rb_q)) b = w_q.data;
    if (rf_wr.en && (rf_wr.addr == s2_ra_q)) a = s3_wdata;
    if (rf_wr.en && (rf_wr.addr == s2_rb_q)) b = s3_wdata;
  end

  always_comb begin
    opc      = s2_instr_q[31:26];
    rt       = s2_instr_q[20:16];
    rd       = s2_instr_q[15:11];
    sh       = s2_instr_q[10:6];
    fn       = s2_instr_q[5:0];
    zimm     = {16'd0, s2_instr_q[15:0]};
    simm     = {{16{s2_instr_q[15]}}, s2_instr_q[15:0]};
    seq      = pc_q + 32'd4;
    ea       = a + simm;
    slot_ext = {22'd0, s2_slot_q};
    npc      = seq;
    alu      = 32'd0;
    wr_en    = 1'b0;
    wr_addr  = rt;
    is_load  = 1'b0;
    dm_we    = 1'b0;
    dm_addr  = ea[AW+1:2];
    dm_wdata = b;
    rsel     = RdNone;
    exec_en  = s2_valid_q && (s2_op_q == OpExec) && run_eff;

    unique case (opc)
      OpcSpecial: begin
        wr_addr = rd;
        unique case (fn)
          FnAddu: begin wr_en = 1'b1; alu = a + b; end
          FnAnd:  begin wr_en = 1'b1; alu = a & b; end
          FnJr:   npc = a;
          FnNor:  begin wr_en = 1'b1; alu = ~(a | b); end
          FnOr:   begin wr_en = 1'b1; alu = a | b; end
          FnSltu: begin wr_en = 1'b1; alu = {31'd0, a < b}; end
          FnSll:  begin wr_en = 1'b1; alu = b << sh; end
          FnSrl:  begin wr_en = 1'b1; alu = b >> sh; end
          FnSubu: begin wr_en = 1'b1; alu = a - b; end
          default: ;
        endcase
      end
      OpcJ:     npc = {seq[31:28], s2_instr_q[25:0], 2'b00};
      OpcJal: begin
        npc     = {seq[31:28], s2_instr_q[25:0], 2'b00};
        wr_en   = 1'b1;
        wr_addr = 5'd31;
        alu     = seq;
      end
      OpcAddiu: begin wr_en = 1'b1; alu = ea; end
      OpcAndi:  begin wr_en = 1'b1; alu = a & zimm; end
      OpcBeq:   if (a == b) npc = seq + {simm[29:0], 2'b00};
      OpcBne:   if (a != b) npc = seq + {simm[29:0], 2'b00};
      OpcLui:   begin wr_en = 1'b1; alu = {s2_instr_q[15:0], 16'd0}; end
      OpcLw:    begin wr_en = 1'b1; is_load = 1'b1; end
      OpcOri:   begin wr_en = 1'b1; alu = a | zimm; end
      OpcSltiu: begin wr_en = 1'b1; alu = {31'd0, a < simm}; end
      OpcSw:    dm_we = 1'b1;
      default: ;
    endcase

    if (!exec_en) begin
      npc     = pc_q;
      wr_en   = 1'b0;
      is_load = 1'b0;
      dm_we   = 1'b0;
    end
    if (wr_addr == 5'd0) wr_en = 1'b0;

    if (s2_valid_q) begin
      unique case (s2_op_q)
        OpExec: ;
        OpPreload: begin
          dm_we    = 1'b1;
          dm_addr  = slot_ext[AW-1:0];
          dm_wdata = s2_wval_q;
        end
        OpReadReg: rsel = RdReg;
        OpReadMem: begin
          rsel    = RdMem;
          dm_addr = slot_ext[AW-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dm_we) dmem[dm_addr] <= dm_wdata;
      dm_rdata_q <= dmem[dm_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= PcReset;
      run_q      <= 1'b1;
      s3_valid_q <= 1'b0;
      s3_wr_q    <= '0;
      w_q        <= '0;
    end else if (en) begin
      pc_q       <= npc;
      run_q      <= run_eff;
      s3_valid_q <= s2_valid_q;
      s3_wr_q    <= '{en: wr_en, addr: wr_addr, data: alu};
      w_q        <= rf_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_load_q <= is_load;
      s3_chk_q  <= exec_en;
      s3_npc_q  <= npc;
      s3_rsel_q <= rsel;
      s3_rv_q   <= a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q[31:0]  <= s3_npc_q;
      out_data_q[32]    <= run_eff;
      out_data_q[64:33] <= (s3_rsel_q == RdMem) ? dm_rdata_q :
                           (s3_rsel_q == RdReg) ? s3_rv_q : 32'd0;
      out_data_q[71:65] <= '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.en |-> rf_wr.addr != 5'd0) else $error("write to register zero");

  a_run_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |=> !run_q) else $error("run flag set again");

  a_stopped_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s2_valid_q && !run_eff) |=> pc_q == $past(pc_q))
    else $error("PC moved while stopped");

  a_stall_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(pc_q) && $stable(s3_npc_q))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
